### hw/rtl/scfr_pkg.sv
`default_nettype none
package scfr_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int POS_W       = 3;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int EMIT_W      = (ADDR_W > POS_W) ? ADDR_W : POS_W;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h04;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_CMD,
        ST_PAYLOAD,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_len;
        logic load_cmd;
        logic clr_cnt;
        logic store_byte;
        logic start_emit;
        logic next_emit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic at_end;
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

### hw/rtl/scfr_ram.sv
`default_nettype none
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/scfr_ctrl.sv
`default_nettype none
module scfr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire scfr_pkg::dp_status_t  status,
    output scfr_pkg::dp_cmd_t          cmd
);

    scfr_pkg::state_t state_reg;
    scfr_pkg::state_t state_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scfr_pkg::ST_IDLE:
            begin
                if (in_acc && status.is_start)
                begin
                    state_next = scfr_pkg::ST_LEN;
                end
            end
            scfr_pkg::ST_LEN:
            begin
                if (in_acc)
                begin
                    state_next = scfr_pkg::ST_CMD;
                end
            end
            scfr_pkg::ST_CMD:
            begin
                if (in_acc)
                begin
                    state_next = scfr_pkg::ST_PAYLOAD;
                end
            end
            scfr_pkg::ST_PAYLOAD:
            begin
                // a bad end byte drops the frame without being taken as a start
                if (in_acc && status.at_end)
                begin
                    state_next = status.is_end ? scfr_pkg::ST_EMIT : scfr_pkg::ST_IDLE;
                end
            end
            scfr_pkg::ST_EMIT:
            begin
                if (out_acc && status.last)
                begin
                    state_next = scfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scfr_pkg::ST_IDLE;
            end
        endcase
    end

    // ready and valid are fixed per state, so a transaction is just the other side's flag
    always_comb
    begin
        in_ready       = 1'b1;
        out_valid      = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            scfr_pkg::ST_IDLE:
            begin
            end
            scfr_pkg::ST_LEN:
            begin
                cmd.load_len = in_valid;
            end
            scfr_pkg::ST_CMD:
            begin
                cmd.load_cmd = in_valid;
                cmd.clr_cnt  = in_valid;
            end
            scfr_pkg::ST_PAYLOAD:
            begin
                cmd.store_byte = in_valid && !status.at_end;
                cmd.start_emit = in_valid && status.at_end && status.is_end;
            end
            scfr_pkg::ST_EMIT:
            begin
                in_ready       = 1'b0;
                out_valid      = 1'b1;
                cmd.next_emit  = out_ready && !status.last;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/scfr_dp.sv
`default_nettype none
module scfr_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [scfr_pkg::BYTE_W-1:0]        rx_byte,
    input  wire scfr_pkg::dp_cmd_t                  cmd,
    output scfr_pkg::dp_status_t                    status,
    output logic      [scfr_pkg::BYTE_W-1:0]        command_code,
    output logic      [scfr_pkg::LEN_W-1:0]         payload_length,
    output logic      [scfr_pkg::BYTE_W-1:0]        data_byte,
    output logic                                    data_valid,
    output logic      [scfr_pkg::POS_W-1:0]         byte_position,
    output logic                                    truncated,
    output logic                                    last
);

    localparam logic [scfr_pkg::LEN_W-1:0] MAX_LEN = scfr_pkg::LEN_W'(scfr_pkg::MAX_PAYLOAD);

    logic [scfr_pkg::LEN_W-1:0]   len_reg;
    logic [scfr_pkg::BYTE_W-1:0]  cmd_reg;
    logic [scfr_pkg::LEN_W-1:0]   cnt_reg;
    logic [scfr_pkg::EMIT_W-1:0]  emit_reg;
    logic [scfr_pkg::EMIT_W-1:0]  emit_next;
    logic [scfr_pkg::LEN_W-1:0]   stored_m1;
    logic                         empty;
    logic                         wr_en;
    logic                         rd_en;
    logic [scfr_pkg::ADDR_W-1:0]  rd_addr;
    logic [scfr_pkg::BYTE_W-1:0]  rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            cmd_reg  <= '0;
            cnt_reg  <= '0;
            emit_reg <= '0;
        end
        else
        begin
            if (cmd.load_len)
            begin
                len_reg <= rx_byte;
            end
            if (cmd.load_cmd)
            begin
                cmd_reg <= rx_byte;
            end
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.store_byte)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.start_emit || cmd.next_emit)
            begin
                emit_reg <= emit_next;
            end
        end
    end

    // drop bytes past the end of the store
    assign wr_en = cmd.store_byte && (cnt_reg < MAX_LEN);

    // prefetch entry 0 on the end byte, then the following entry on each accept but the last
    assign emit_next = cmd.next_emit ? emit_reg + 1'b1 : '0;
    assign rd_en     = cmd.start_emit || cmd.next_emit;
    assign rd_addr   = emit_next[scfr_pkg::ADDR_W-1:0];

    scfr_ram #(
        .WIDTH (scfr_pkg::BYTE_W),
        .DEPTH (scfr_pkg::MAX_PAYLOAD),
        .AW    (scfr_pkg::ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[scfr_pkg::ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign empty     = (len_reg == '0);
    assign truncated = (len_reg > MAX_LEN);
    assign stored_m1 = (truncated ? MAX_LEN : len_reg) - 1'b1;

    assign status.is_start = (rx_byte == scfr_pkg::START_BYTE);
    assign status.is_end   = (rx_byte == scfr_pkg::END_BYTE);
    assign status.at_end   = (cnt_reg == len_reg);
    assign status.last     = last;

    assign command_code   = cmd_reg;
    assign payload_length = len_reg;
    assign data_valid     = !empty;
    assign data_byte      = empty ? '0 : rd_data;
    assign byte_position  = empty ? '0 : emit_reg[scfr_pkg::POS_W-1:0];
    assign last           = empty ||
        ({{(scfr_pkg::LEN_W-scfr_pkg::EMIT_W){1'b0}}, emit_reg} == stored_m1);

endmodule
`default_nettype wire

### hw/rtl/serial_command_frame_receiver.sv
// Parses serial frames laid out as start byte 0x01, length, command, payload and
// end byte 0x04, one rx_byte per transaction; bytes outside a frame are skipped.
// While a frame is being parsed one byte is taken every cycle. Once a good end
// byte arrives, in_ready drops and the frame is delivered as a run of results,
// one per stored payload byte (up to 8, excess bytes are discarded and flagged as
// truncated), or a single result with data_valid low for an empty payload. The
// run moves to the next result each time one is taken; the payload store
// is read one entry ahead, so the first result is shown the cycle after the end
// byte. in_ready returns the cycle after the last result is taken. A frame with
// a wrong end byte produces no result.
`default_nettype none
module serial_command_frame_receiver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [scfr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [scfr_pkg::BYTE_W-1:0]    command_code,
    output logic      [scfr_pkg::LEN_W-1:0]     payload_length,
    output logic      [scfr_pkg::BYTE_W-1:0]    data_byte,
    output logic                                data_valid,
    output logic      [scfr_pkg::POS_W-1:0]     byte_position,
    output logic                                truncated,
    output logic                                last
);

    scfr_pkg::dp_cmd_t    dp_cmd;
    scfr_pkg::dp_status_t dp_status;

    scfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    scfr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .command_code   (command_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .byte_position  (byte_position),
        .truncated      (truncated),
        .last           (last)
    );

endmodule
`default_nettype wire

### hw/rtl/scfr_checker.sv
`default_nettype none
module scfr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [scfr_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [scfr_pkg::BYTE_W-1:0]    command_code,
    input  wire logic [scfr_pkg::LEN_W-1:0]     payload_length,
    input  wire logic [scfr_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic                           data_valid,
    input  wire logic [scfr_pkg::POS_W-1:0]     byte_position,
    input  wire logic                           truncated,
    input  wire logic                           last
);

    // hold a stalled input
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(rx_byte))
        else $error("stalled input changed");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
        $stable(byte_position) && $stable(last) && $stable(command_code))
        else $error("stalled result changed");

    a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a run is being delivered");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> last && data_byte == '0 &&
        byte_position == '0 && !truncated && payload_length == '0)
        else $error("malformed empty-frame result");

    a_run_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid &&
        byte_position == $past(byte_position) + 1'b1 &&
        $stable(command_code) && $stable(payload_length))
        else $error("run did not advance to the next payload byte");

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command_code   (command_code),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .data_valid     (data_valid),
    .byte_position  (byte_position),
    .truncated      (truncated),
    .last           (last)
);
`default_nettype wire

### tb/tb_serial_command_frame_receiver.sv
`timescale 1ns / 1ps

module tb_serial_command_frame_receiver;

    localparam int RESET_CYCLES   = 11;
    localparam int FRAME_HDR_LEN  = 3;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 50;

    typedef struct packed {
        logic [scfr_pkg::BYTE_W-1:0] command_code;
        logic [scfr_pkg::LEN_W-1:0]  payload_length;
        logic [scfr_pkg::BYTE_W-1:0] data_byte;
        logic                        data_valid;
        logic [scfr_pkg::POS_W-1:0]  byte_position;
        logic                        truncated;
        logic                        last;
    } frame_result_t;

    // Tracks the frame parser and holds the results each completed frame must produce.
    class frame_scoreboard;
        logic [8:0]                  frame_pos;
        logic [scfr_pkg::LEN_W-1:0]  frame_len;
        logic [scfr_pkg::BYTE_W-1:0] frame_cmd;
        logic [scfr_pkg::BYTE_W-1:0] payload_mem [scfr_pkg::MAX_PAYLOAD];
        frame_result_t               pending_results [$];
        int                          faults;
        int                          results_seen;
        int                          frames_done;

        function new();
            frame_pos    = '0;
            frame_len    = '0;
            frame_cmd    = '0;
            faults       = 0;
            results_seen = 0;
            frames_done  = 0;
        endfunction

        function void note_input(input logic [scfr_pkg::BYTE_W-1:0] b);
            int            stored;
            frame_result_t r;
            if (frame_pos == 0)
            begin
                if (b == scfr_pkg::START_BYTE)
                    frame_pos = 9'd1;
            end
            else if (frame_pos == 1)
            begin
                frame_len = b;
                frame_pos = 9'd2;
            end
            else if (frame_pos == 2)
            begin
                frame_cmd = b;
                frame_pos = 9'd3;
            end
            else if (frame_pos < frame_len + FRAME_HDR_LEN)
            begin
                // keep only what fits in the store, but consume the full length
                if (frame_pos - FRAME_HDR_LEN < scfr_pkg::MAX_PAYLOAD)
                    payload_mem[frame_pos - FRAME_HDR_LEN] = b;
                frame_pos = frame_pos + 9'd1;
            end
            else
            begin
                frame_pos = '0;
                if (b == scfr_pkg::END_BYTE)
                begin
                    frames_done++;
                    r.command_code   = frame_cmd;
                    r.payload_length = frame_len;
                    if (frame_len == 0)
                    begin
                        r.data_byte     = '0;
                        r.data_valid    = 1'b0;
                        r.byte_position = '0;
                        r.truncated     = 1'b0;
                        r.last          = 1'b1;
                        pending_results.push_back(r);
                    end
                    else
                    begin
                        stored = (frame_len > scfr_pkg::MAX_PAYLOAD) ?
                                 scfr_pkg::MAX_PAYLOAD : frame_len;
                        for (int i = 0; i < stored; i++)
                        begin
                            r.data_byte     = payload_mem[i];
                            r.data_valid    = 1'b1;
                            r.byte_position = i[scfr_pkg::POS_W-1:0];
                            r.truncated     = (frame_len > scfr_pkg::MAX_PAYLOAD);
                            r.last          = (i == stored - 1);
                            pending_results.push_back(r);
                        end
                    end
                end
            end
        endfunction

        function void report(input string what, input frame_result_t want,
                             input frame_result_t got);
            faults++;
            if (faults <= 10)
            begin
                $display("%0t: %s", $time, what);
                $display("  expected cmd=%h len=%h data=%h dv=%b pos=%0d trunc=%b last=%b",
                         want.command_code, want.payload_length, want.data_byte,
                         want.data_valid, want.byte_position, want.truncated, want.last);
                $display("  actual   cmd=%h len=%h data=%h dv=%b pos=%0d trunc=%b last=%b",
                         got.command_code, got.payload_length, got.data_byte,
                         got.data_valid, got.byte_position, got.truncated, got.last);
            end
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t want;
            string         diff;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report("result with no frame pending", '0, got);
                return;
            end
            want = pending_results.pop_front();
            diff = "";
            if (got.command_code !== want.command_code)     diff = {diff, " command_code"};
            if (got.payload_length !== want.payload_length) diff = {diff, " payload_length"};
            if (got.data_byte !== want.data_byte)           diff = {diff, " data_byte"};
            if (got.data_valid !== want.data_valid)         diff = {diff, " data_valid"};
            if (got.byte_position !== want.byte_position)   diff = {diff, " byte_position"};
            if (got.truncated !== want.truncated)           diff = {diff, " truncated"};
            if (got.last !== want.last)                     diff = {diff, " last"};
            if (diff != "")
                report({"field mismatch:", diff}, want, got);
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [scfr_pkg::BYTE_W-1:0]   rx_byte = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [scfr_pkg::BYTE_W-1:0]   command_code;
    logic [scfr_pkg::LEN_W-1:0]    payload_length;
    logic [scfr_pkg::BYTE_W-1:0]   data_byte;
    logic                          data_valid;
    logic [scfr_pkg::POS_W-1:0]    byte_position;
    logic                          truncated;
    logic                          last;

    frame_scoreboard board = new();
    int              items_sent = 0;
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    bit              hold_request = 1'b0;
    int              hold_left = 0;
    int              quiet_cycles = 0;

    logic [scfr_pkg::BYTE_W-1:0] directed_bytes [$] = '{
        // stray bytes while idle
        8'h00, 8'hFF,
        // empty payload
        scfr_pkg::START_BYTE, 8'h00, 8'hFF, scfr_pkg::END_BYTE,
        // wrong end byte that looks like a start byte, then bytes that must be ignored
        scfr_pkg::START_BYTE, 8'h00, 8'h33, scfr_pkg::START_BYTE,
        8'h00, 8'h7E, scfr_pkg::END_BYTE,
        // one byte past the store: truncated run of full length
        scfr_pkg::START_BYTE, 8'd9, 8'hA5,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55,
        scfr_pkg::END_BYTE
    };

    serial_command_frame_receiver DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .command_code   (command_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .byte_position  (byte_position),
        .truncated      (truncated),
        .last           (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check each transaction, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(frame_result_t'{command_code, payload_length, data_byte,
                                                   data_valid, byte_position, truncated,
                                                   last});
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready   <= 1'b0;
                hold_left   <= HOLD_CYCLES;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[serial_command_frame_receiver] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [scfr_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(b);
        items_sent++;
    endtask

    task automatic offer_frame(input int len, input int body,
                               input logic [scfr_pkg::BYTE_W-1:0] tail, input bit with_tail);
        send_byte(scfr_pkg::START_BYTE);
        send_byte(8'(len));
        send_byte(8'($urandom_range(255)));
        repeat (body)
            send_byte(8'($urandom_range(255)));
        if (with_tail)
            send_byte(tail);
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 0;
        if (roll < 80)
            return $urandom_range(scfr_pkg::MAX_PAYLOAD, 1);
        if (roll < 95)
            return $urandom_range(16, scfr_pkg::MAX_PAYLOAD + 1);
        return $urandom_range(60, 17);
    endfunction

    // mostly good frames; the rest are bad end bytes, frames cut short and stray bytes
    task automatic run_random(input int n_items);
        int                          goal;
        int                          roll;
        int                          len;
        logic [scfr_pkg::BYTE_W-1:0] tail;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            roll = $urandom_range(99);
            len  = pick_length();
            if (roll < 72)
                offer_frame(len, len, scfr_pkg::END_BYTE, 1'b1);
            else if (roll < 84)
            begin
                do
                    tail = 8'($urandom_range(255));
                while (tail == scfr_pkg::END_BYTE);
                if ($urandom_range(2) == 0)
                    tail = scfr_pkg::START_BYTE;
                offer_frame(len, len, tail, 1'b1);
            end
            else if (roll < 90)
                offer_frame(len, $urandom_range(len), scfr_pkg::END_BYTE, 1'b0);
            else
            begin
                do
                    tail = 8'($urandom_range(255));
                while (tail == scfr_pkg::START_BYTE);
                send_byte(tail);
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);

        // hold off the result side so the block backs up into its input
        hold_request = 1'b1;
        run_random(PHASE_ITEMS);

        send_idle_pct = 48;
        run_random(PHASE_ITEMS);

        send_idle_pct = 0;
        stall_pct     = 48;
        run_random(PHASE_ITEMS);

        send_idle_pct = 11;
        stall_pct     = 11;
        run_random(PHASE_ITEMS);

        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d bytes forming %0d good frames; checked %0d results, %0d faults",
                 items_sent, board.frames_done, board.results_seen, board.faults);
        $display("covered empty, full, truncated and long payloads, bad end bytes, "
                 , "stray bytes and idle/stall mixes");
        if (board.faults == 0)
            $display("[serial_command_frame_receiver] OK");
        else
            $display("[serial_command_frame_receiver] ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/scfr_pkg.sv
hw/rtl/scfr_ram.sv
hw/rtl/scfr_ctrl.sv
hw/rtl/scfr_dp.sv
hw/rtl/serial_command_frame_receiver.sv
hw/rtl/scfr_checker.sv
tb/tb_serial_command_frame_receiver.sv
